FILE: design/sound_burst_trigger_defines.svh
// Assertion macros shared by the RTL files of the sound burst trigger.
`ifndef SOUND_BURST_TRIGGER_DEFINES_SVH
`define SOUND_BURST_TRIGGER_DEFINES_SVH

`ifndef ASSERT_OFF

// Checked at every rising edge while the block is out of reset.
`define SBT_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every rising edge, reset included.
`define SBT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define SBT_ASSERT(lbl, clk, rst_n, prop, msg)
`define SBT_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

FILE: design/sbt_pkg.sv
`default_nettype none

package sbt_pkg;

  localparam int SAMPLE_W = 10;
  localparam int SENS_W   = 7;
  localparam int PERCENT  = 100;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_MULA,
    ST_MULB,
    ST_DONE
  } sbt_state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

`default_nettype wire

FILE: design/sbt_if.sv
`default_nettype none

interface sbt_in_if;
  logic                       valid;
  logic                       ready;
  logic [sbt_pkg::SAMPLE_W-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface sbt_out_if;
  logic                       valid;
  logic                       ready;
  logic                       trigger;
  logic [sbt_pkg::SAMPLE_W-1:0] average_level;
  logic                       average_valid;

  modport source (output valid, output trigger, output average_level,
                  output average_valid, input ready);
  modport sink   (input valid, input trigger, input average_level,
                  input average_valid, output ready);
endinterface

`default_nettype wire

FILE: design/sbt_divider.sv
`default_nettype none

`include "sound_burst_trigger_defines.svh"

module sbt_divider #(
  parameter int DIVIDEND_W = 14,
  parameter int DIVISOR    = 10
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  input  wire logic [DIVIDEND_W-1:0] dividend,
  output logic      [DIVIDEND_W-1:0] quotient,
  output sbt_pkg::div_stat_t         status
);
  import sbt_pkg::*;

  // floor(x / DIVISOR) equals (x * RECIP) >> SHIFT for every x below 2**DIVIDEND_W
  // when RECIP is 2**SHIFT / DIVISOR rounded up.
  localparam int SHIFT   = DIVIDEND_W + $clog2(DIVISOR);
  localparam int RECIP_W = DIVIDEND_W + 1;
  localparam int PROD_W  = DIVIDEND_W + RECIP_W;
  localparam longint unsigned RECIP =
    ((64'd1 << SHIFT) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);

  logic [DIVIDEND_W-1:0] num_r;
  logic [DIVIDEND_W-1:0] quo_r;
  logic                  busy_r;
  logic                  done_r;

  logic [PROD_W-1:0] prod;

  assign prod = PROD_W'(num_r) * PROD_W'(RECIP_W'(RECIP));

  // The dividend is registered on start and multiplied in the following cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= dividend;
    end else if (busy_r) begin
      quo_r <= DIVIDEND_W'(prod >> SHIFT);
    end
  end

  assign quotient    = quo_r;
  assign status.busy = busy_r;
  assign status.done = done_r;

  `SBT_ASSERT(a_div_one_step, clk, rst_n, (busy_r && !start) |=> !busy_r, "multiply ran long")
  `SBT_ASSERT(a_div_done_after_busy, clk, rst_n, done_r |-> $past(busy_r), "done without busy")
  `SBT_ASSERT(a_div_stay_idle, clk, rst_n, (!busy_r && !start) |=> !busy_r, "busy without start")

endmodule

`default_nettype wire

FILE: design/sound_burst_trigger.sv
// Sound burst trigger: window average of microphone samples and rise detector.
// Each accepted sample runs through the states MULA (rise times 100) and MULB
// (average times sens + 1) to DONE; the sample that closes a window waits in DIV first
// for the reciprocal multiply of the sum. A new sample is taken only in IDLE; a result
// still held in the output register keeps the input stalled.
// Reset (rst_n low, synchronous) clears the window, the average and the output valid flag.
`default_nettype none

`include "sound_burst_trigger_defines.svh"

module sound_burst_trigger #(
  parameter int WINDOW_LEN = 10
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       cfg_we,
  input  wire logic [sbt_pkg::SENS_W-1:0] cfg_wdata,
  sbt_in_if.sink                          in_ch,
  sbt_out_if.source                       out_ch
);
  import sbt_pkg::*;

  localparam int IDX_W  = $clog2(WINDOW_LEN);
  localparam int SUM_W  = SAMPLE_W + IDX_W;
  localparam int MULY_W = SENS_W + 1;
  localparam int PROD_W = SAMPLE_W + MULY_W;

  sbt_state_t state_r, state_nxt;

  logic [SENS_W-1:0]   sens_r;
  logic [IDX_W-1:0]    idx_r;
  logic [SUM_W-1:0]    sum_r;
  logic [SAMPLE_W-1:0] cur_r;
  logic [SAMPLE_W-1:0] avg_r;
  logic                avg_ok_r;
  logic                gt_r;
  logic [PROD_W-1:0]   prod_a_r;
  logic [PROD_W-1:0]   prod_b_r;
  logic                oval_r;
  logic                otrig_r;
  logic [SAMPLE_W-1:0] olvl_r;
  logic                ook_r;

  logic in_rdy;
  logic sel_b;
  logic out_load;
  logic in_acc;
  logic last_slot;
  logic [SUM_W-1:0] sum_in;

  logic [SUM_W-1:0] div_q;
  div_stat_t        div_st;

  assign in_acc    = in_ch.valid && in_ch.ready;
  assign last_slot = idx_r == IDX_W'(WINDOW_LEN - 1);
  assign sum_in    = sum_r + SUM_W'(in_ch.sample);

  sbt_divider #(
    .DIVIDEND_W (SUM_W),
    .DIVISOR    (WINDOW_LEN)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (in_acc && last_slot),
    .dividend (sum_in),
    .quotient (div_q),
    .status   (div_st)
  );

  // floor(rise * 100 / avg) > sens is the same as rise * 100 >= (sens + 1) * avg,
  // which also covers a zero average. One multiplier forms both products.
  logic [SAMPLE_W-1:0] mul_x;
  logic [MULY_W-1:0]   mul_y;
  logic [PROD_W-1:0]   mul_p;

  assign mul_x = sel_b ? avg_r : (cur_r - avg_r);
  assign mul_y = sel_b ? ({1'b0, sens_r} + MULY_W'(1)) : MULY_W'(PERCENT);
  assign mul_p = PROD_W'(mul_x) * PROD_W'(mul_y);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_acc) state_nxt = last_slot ? ST_DIV : ST_MULA;
      ST_DIV:  if (div_st.done) state_nxt = ST_MULA;
      ST_MULA: state_nxt = ST_MULB;
      ST_MULB: state_nxt = ST_DONE;
      ST_DONE: if (out_load) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_rdy   = 1'b0;
    sel_b    = 1'b0;
    out_load = 1'b0;
    unique case (state_r)
      ST_IDLE: in_rdy = 1'b1;
      ST_DIV:  ;
      ST_MULA: ;
      ST_MULB: sel_b = 1'b1;
      ST_DONE: out_load = !oval_r || out_ch.ready;
      default: ;
    endcase
  end

  assign in_ch.ready = in_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      sens_r   <= '0;
      idx_r    <= '0;
      sum_r    <= '0;
      avg_r    <= '0;
      avg_ok_r <= 1'b0;
      oval_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) sens_r <= cfg_wdata;
      if (in_acc) begin
        if (last_slot) begin
          idx_r <= '0;
          sum_r <= '0;
        end else begin
          idx_r <= idx_r + 1'b1;
          sum_r <= sum_in;
        end
      end
      if (state_r == ST_DIV && div_st.done) begin
        avg_r    <= div_q[SAMPLE_W-1:0];
        avg_ok_r <= 1'b1;
      end
      if (out_load) oval_r <= 1'b1;
      else if (out_ch.ready) oval_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) cur_r <= in_ch.sample;
    if (state_r == ST_MULA) begin
      prod_a_r <= mul_p;
      gt_r     <= cur_r > avg_r;
    end
    if (state_r == ST_MULB) prod_b_r <= mul_p;
    if (out_load) begin
      otrig_r <= avg_ok_r && gt_r && (prod_a_r >= prod_b_r);
      olvl_r  <= avg_r;
      ook_r   <= avg_ok_r;
    end
  end

  assign out_ch.valid         = oval_r;
  assign out_ch.trigger       = otrig_r;
  assign out_ch.average_level = olvl_r;
  assign out_ch.average_valid = ook_r;

  `SBT_ASSERT(a_close_goes_div, clk, rst_n, (in_acc && last_slot) |=> state_r == ST_DIV, "window close skipped divide")
  `SBT_ASSERT(a_div_running, clk, rst_n, (state_r == ST_DIV) |-> (div_st.busy || div_st.done), "divider idle in DIV")
  `SBT_ASSERT(a_idx_bound, clk, rst_n, idx_r <= IDX_W'(WINDOW_LEN - 1), "fill index past window")
  `SBT_ASSERT(a_trig_needs_avg, clk, rst_n, (oval_r && otrig_r) |-> ook_r, "trigger without valid average")

endmodule

`default_nettype wire

FILE: tb/sv/tb_sound_burst_trigger.sv
`timescale 1ns / 1ps

module tb_sound_burst_trigger;
  import sbt_pkg::*;

  localparam int WIN_LEN     = 10;
  localparam int DIR_N       = 24;
  localparam int PHASE_ITEMS = 240;
  localparam int N_PHASES    = 7;
  localparam int HOLD_CYCLES = 300;
  localparam int SETTLE      = 30;
  localparam int CYCLE_LIMIT = 400000;
  localparam int IDLE_PCT    = 11;
  localparam int LEVEL_MAX   = (1 << SAMPLE_W) - 1;

  typedef struct packed {
    logic                trigger;
    logic [SAMPLE_W-1:0] average_level;
    logic                average_valid;
  } burst_result_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic                typed;
    burst_result_t       res;
  } stim_row_t;

  typedef enum {LVL_SILENT, LVL_LOW, LVL_MID, LVL_NOISE} level_mode_t;

  logic                clk;
  logic                rst_n;
  logic                cfg_we;
  logic [SENS_W-1:0]   cfg_wdata;

  sbt_in_if  in_ch ();
  sbt_out_if out_ch ();

  sound_burst_trigger #(.WINDOW_LEN(WIN_LEN)) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  // Predictor state, kept in step with every accepted sample beat.
  logic [SAMPLE_W-1:0] level_win [WIN_LEN];
  int                  fill_pos;
  logic [SAMPLE_W-1:0] win_avg;
  logic                avg_ok;
  logic [SENS_W-1:0]   sens_q;

  burst_result_t       results_q [$];
  int                  fail_cnt = 0;
  int                  cycle_cnt = 0;
  logic                quiet;
  logic                hold_ask;
  level_mode_t         win_mode;
  int                  win_base;

  // Opening rows: a window with one full-scale sample, an all-zero window,
  // then rises over a zero average.
  stim_row_t dir_rows [DIR_N] = '{
    '{10'd1023, 1'b1, '{1'b0, 10'd0,   1'b0}},
    '{10'd0,    1'b1, '{1'b0, 10'd0,   1'b0}},
    '{10'd0,    1'b1, '{1'b0, 10'd0,   1'b0}},
    '{10'd0,    1'b1, '{1'b0, 10'd0,   1'b0}},
    '{10'd0,    1'b1, '{1'b0, 10'd0,   1'b0}},
    '{10'd0,    1'b1, '{1'b0, 10'd0,   1'b0}},
    '{10'd0,    1'b1, '{1'b0, 10'd0,   1'b0}},
    '{10'd0,    1'b1, '{1'b0, 10'd0,   1'b0}},
    '{10'd0,    1'b1, '{1'b0, 10'd0,   1'b0}},
    '{10'd0,    1'b1, '{1'b0, 10'd102, 1'b1}},
    '{10'd0,    1'b1, '{1'b0, 10'd102, 1'b1}},
    '{10'd0,    1'b1, '{1'b0, 10'd102, 1'b1}},
    '{10'd0,    1'b1, '{1'b0, 10'd102, 1'b1}},
    '{10'd0,    1'b1, '{1'b0, 10'd102, 1'b1}},
    '{10'd0,    1'b1, '{1'b0, 10'd102, 1'b1}},
    '{10'd0,    1'b1, '{1'b0, 10'd102, 1'b1}},
    '{10'd0,    1'b1, '{1'b0, 10'd102, 1'b1}},
    '{10'd0,    1'b1, '{1'b0, 10'd102, 1'b1}},
    '{10'd0,    1'b1, '{1'b0, 10'd102, 1'b1}},
    '{10'd0,    1'b1, '{1'b0, 10'd0,   1'b1}},
    '{10'd1,    1'b1, '{1'b1, 10'd0,   1'b1}},
    '{10'd1023, 1'b1, '{1'b1, 10'd0,   1'b1}},
    '{10'd0,    1'b1, '{1'b0, 10'd0,   1'b1}},
    '{10'd512,  1'b0, '{1'b0, 10'd0,   1'b0}}
  };

  function automatic burst_result_t predict_burst(input logic [SAMPLE_W-1:0] s);
    burst_result_t r;
    int            total;
    int            rise;
    level_win[fill_pos] = s;
    if (fill_pos == WIN_LEN - 1) begin
      fill_pos = 0;
      avg_ok   = 1'b1;
      total    = 0;
      for (int i = 0; i < WIN_LEN; i++) total += int'(level_win[i]);
      win_avg  = SAMPLE_W'(total / WIN_LEN);
    end else begin
      fill_pos++;
    end
    r.trigger = 1'b0;
    if (avg_ok && s > win_avg) begin
      // A zero average makes the rise unbounded, so it always fires.
      if (win_avg == '0) begin
        r.trigger = 1'b1;
      end else begin
        rise      = (int'(s) - int'(win_avg)) * PERCENT / int'(win_avg);
        r.trigger = rise > int'(sens_q);
      end
    end
    r.average_level = win_avg;
    r.average_valid = avg_ok;
    return r;
  endfunction

  // Each window gets a loudness profile so that quiet rooms with sudden
  // bursts show up often enough to fire at high sensitivity.
  function automatic logic [SAMPLE_W-1:0] next_sample();
    int v;
    if (fill_pos == 0) begin
      case ($urandom_range(0, 19))
        0, 1:          win_mode = LVL_SILENT;
        2, 3, 4, 5, 6: win_mode = LVL_NOISE;
        7, 8, 9, 10:   win_mode = LVL_MID;
        default:       win_mode = LVL_LOW;
      endcase
      win_base = (win_mode == LVL_LOW) ? int'($urandom_range(1, 80)) :
                                         int'($urandom_range(200, 700));
    end
    if ($urandom_range(0, 99) < 12) return SAMPLE_W'($urandom_range(0, LEVEL_MAX));
    case (win_mode)
      LVL_SILENT: v = 0;
      LVL_NOISE:  v = int'($urandom_range(0, LEVEL_MAX));
      default:    v = win_base + int'($urandom_range(0, 60)) - 30;
    endcase
    if (v < 0) v = 0;
    if (v > LEVEL_MAX) v = LEVEL_MAX;
    return SAMPLE_W'(v);
  endfunction

  task automatic send_sample(input logic [SAMPLE_W-1:0] s, input logic typed,
                             input burst_result_t typed_res);
    burst_result_t r;
    while (!quiet && $urandom_range(0, 99) < IDLE_PCT) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
    end
    @(negedge clk);
    in_ch.valid  <= 1'b1;
    in_ch.sample <= s;
    do @(posedge clk); while (!in_ch.ready);
    r = predict_burst(s);
    results_q.push_back(typed ? typed_res : r);
  endtask

  task automatic drain_results();
    while (results_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_sensitivity(input logic [SENS_W-1:0] v);
    @(negedge clk);
    in_ch.valid <= 1'b0;
    drain_results();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we    <= 1'b0;
    sens_q = v;
  endtask

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Result side: random stalls, a quiet stretch, and one long hold-off.
  initial begin : result_sink
    int hold_left;
    int held;
    hold_left    = 0;
    held         = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else if (hold_ask && !held) begin
        out_ch.ready <= 1'b0;
        hold_left = HOLD_CYCLES - 1;
        held      = 1;
      end else begin
        out_ch.ready <= quiet || ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  always @(posedge clk) begin : check_results
    burst_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (results_q.size() == 0) begin
        $display("%0t: result beat with nothing expected, got trigger %0b avg %0d valid %0b",
                 $time, out_ch.trigger, out_ch.average_level, out_ch.average_valid);
        fail_cnt++;
      end else begin
        want = results_q.pop_front();
        if (out_ch.trigger !== want.trigger) begin
          $display("%0t: trigger expected %0b actual %0b",
                   $time, want.trigger, out_ch.trigger);
          fail_cnt++;
        end
        if (out_ch.average_level !== want.average_level) begin
          $display("%0t: average_level expected %0d actual %0d",
                   $time, want.average_level, out_ch.average_level);
          fail_cnt++;
        end
        if (out_ch.average_valid !== want.average_valid) begin
          $display("%0t: average_valid expected %0b actual %0b",
                   $time, want.average_valid, out_ch.average_valid);
          fail_cnt++;
        end
      end
    end
  end

  initial begin : stimulus
    logic [SENS_W-1:0] phase_sens [N_PHASES];
    quiet        = 1'b0;
    hold_ask     = 1'b0;
    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_wdata    = '0;
    in_ch.valid  = 1'b0;
    in_ch.sample = '0;
    fill_pos     = 0;
    win_avg      = '0;
    avg_ok       = 1'b0;
    sens_q       = '0;
    win_mode     = LVL_NOISE;
    win_base     = 0;
    for (int i = 0; i < WIN_LEN; i++) level_win[i] = '0;
    phase_sens[0] = 7'd127;
    phase_sens[1] = 7'd100;
    phase_sens[2] = 7'd0;
    phase_sens[3] = 7'd1;
    for (int i = 4; i < N_PHASES; i++) phase_sens[i] = SENS_W'($urandom_range(0, 127));

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) send_sample(dir_rows[i].sample, dir_rows[i].typed, dir_rows[i].res);

    for (int p = 0; p < N_PHASES; p++) begin
      write_sensitivity(phase_sens[p]);
      quiet = (p == 2);
      if (p == 3) begin
        // The result side stops taking beats while samples keep coming.
        @(posedge clk);
        hold_ask = 1'b1;
      end
      repeat (PHASE_ITEMS) send_sample(next_sample(), 1'b0, '0);
    end

    @(negedge clk);
    in_ch.valid <= 1'b0;
    drain_results();
    if (fail_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+design
design/sbt_pkg.sv
design/sbt_if.sv
design/sbt_divider.sv
design/sound_burst_trigger.sv
tb/sv/tb_sound_burst_trigger.sv
